// File: rtl/iwbt_pkg.sv
// Package for the IPv4 wildcard pattern table: request codes, widths and the octet match.
// Used by ip_wildcard_blacklist_table; depends on nothing else.
`default_nettype none

package iwbt_pkg;

	// Request modes.
	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_ADD   = 2'd1;
	localparam logic [1:0] MODE_CHECK = 2'd2;

	// A pattern octet of all ones matches any address octet.
	localparam logic [7:0] WILDCARD_OCTET = 8'hFF;

	localparam int PATTERN_W     = 32;
	localparam int COUNT_OUT_W   = 9;
	localparam int TABLE_ENTRIES_DEF = 256;

	typedef logic [PATTERN_W-1:0] pattern_t;

	// True when every octet of the pattern is a wildcard or equals the address octet.
	function automatic logic octets_match(input pattern_t pat, input pattern_t addr);
		logic ok;
		ok = 1'b1;
		for (int k = 0; k < 4; k++) begin
			if (pat[8*k +: 8] != WILDCARD_OCTET && pat[8*k +: 8] != addr[8*k +: 8]) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

endpackage

`default_nettype wire

// File: rtl/iwbt_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; used by ip_wildcard_blacklist_table for the pattern store.
`default_nettype none

module iwbt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write and registered read; contents are undefined until written.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// File: rtl/ip_wildcard_blacklist_table.sv
// Top level of the IPv4 wildcard pattern table: request decode, scan sequencer, response register.
// Depends on iwbt_pkg and iwbt_ram.
`default_nettype none

// Each request clears the table, appends one pattern (or sets status if the table is full),
// or checks one address against the stored patterns, and gives exactly one response. Clear,
// add and the unused mode answer in the cycle after acceptance, as does a check of an empty
// table. Otherwise a check reads the stored patterns (up to TABLE_ENTRIES) in order, one per
// cycle through the single read port of the pattern RAM, stops at the first match and
// answers from ST_DONE once the response register is free. One request is worked on at a
// time. The table needs no clearing pass after reset: a fill count marks the valid entries,
// so a clear only resets the count. entry_count is the count modulo 512.
module ip_wildcard_blacklist_table #(
	parameter int TABLE_ENTRIES = iwbt_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [31:0] word,
	output logic             rsp_valid,
	input  wire logic        rsp_ready,
	output logic             hit,
	output logic             status,
	output logic [iwbt_pkg::COUNT_OUT_W-1:0] entry_count
);

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int OW = iwbt_pkg::COUNT_OUT_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]              state_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           idx_q;
	iwbt_pkg::pattern_t      word_q;
	logic                    rd_valid_s1;
	logic                    res_hit_q;

	logic                    rsp_valid_q;
	logic                    hit_q;
	logic                    status_q;
	logic [OW-1:0]           entry_count_q;

	logic                    accept;
	logic                    out_free;
	logic                    full;
	logic                    issue;
	logic                    found;
	logic                    exhausted;
	logic                    wr_en;
	iwbt_pkg::pattern_t      rd_data;

	logic                    load_out;
	logic                    load_hit;
	logic                    load_status;
	logic [CW-1:0]           count_d;
	logic [1:0]              state_d;
	logic [CW+OW-1:0]        count_ext;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE) && out_free;
	assign accept    = req_valid && req_ready;
	assign full      = (count_q == CW'(TABLE_ENTRIES));

	// Scan reads one entry per cycle until every stored entry has been issued or a match ends the scan.
	assign issue     = (state_q == ST_SCAN) && (idx_q < count_q);
	assign found     = rd_valid_s1 && iwbt_pkg::octets_match(rd_data, word_q);
	assign exhausted = rd_valid_s1 && !found && (idx_q == count_q);

	assign wr_en = accept && (mode == iwbt_pkg::MODE_ADD) && !full;

	iwbt_ram #(
		.WIDTH (iwbt_pkg::PATTERN_W),
		.DEPTH (TABLE_ENTRIES)
	) u_pattern_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (word),
		.rd_en   (issue),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	// Next-state and response decode.
	always_comb begin
		load_out    = 1'b0;
		load_hit    = 1'b0;
		load_status = 1'b0;
		count_d     = count_q;
		state_d     = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (mode)
						iwbt_pkg::MODE_CLEAR: begin
							count_d  = '0;
							load_out = 1'b1;
						end
						iwbt_pkg::MODE_ADD: begin
							load_out = 1'b1;
							if (full) begin
								load_status = 1'b1;
							end else begin
								count_d = count_q + CW'(1);
							end
						end
						iwbt_pkg::MODE_CHECK: begin
							if (count_q == '0) begin
								load_out = 1'b1;
							end else begin
								state_d = ST_SCAN;
							end
						end
						default: begin
							load_out = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (found || exhausted) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					load_hit = res_hit_q;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign count_ext = {{OW{1'b0}}, count_d};

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			rd_valid_s1 <= 1'b0;
			idx_q       <= '0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			rd_valid_s1 <= issue;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (accept) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + CW'(1);
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			word_q <= word;
		end
		if (state_q == ST_SCAN) begin
			res_hit_q <= found;
		end
		if (load_out) begin
			hit_q         <= load_hit;
			status_q      <= load_status;
			entry_count_q <= count_ext[OW-1:0];
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign hit         = hit_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;

endmodule

`default_nettype wire
